// ===== sv/tae_pkg.sv =====
// ============================================================================
// tae_pkg: shared types and constants of the acceleration estimator
// Default widths, register reset values, register indexes and the sequencer
// states used by the estimator and its channel interfaces.
// ============================================================================
package tae_pkg;

   // Default field widths.
   localparam int VALUE_BITS_DEF      = 32;
   localparam int TIME_BITS_DEF       = 48;
   localparam int ALPHA_FRAC_BITS_DEF = 16;

   // Configuration port.
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_DATA_BITS-1:0] FILTER_TAU_RESET     = 32'd20_000_000;
   localparam logic [CSR_DATA_BITS-1:0] PUBLISH_PERIOD_RESET = 32'd2_000_000;

   // Nanoseconds per second, the scale of the derivative.
   localparam int NS_BITS = 30;
   localparam logic [NS_BITS-1:0] NS_PER_SEC = 30'd1_000_000_000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CFG_FILTER_TAU     = 1'b0,
      CFG_PUBLISH_PERIOD = 1'b1
   } cfg_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DT,
      ST_ALPHA_SEL,
      ST_ALPHA_DIV,
      ST_DV,
      ST_ABS,
      ST_MUL,
      ST_DIV,
      ST_RAW,
      ST_DIFF,
      ST_ROUND,
      ST_UPDATE,
      ST_ELAPSED,
      ST_THROTTLE,
      ST_OUT
   } state_type;

endpackage

// ===== sv/tae_req_if.sv =====
// ============================================================================
// tae_req_if: input channel of the acceleration estimator
// One word is a simulation step: a timestamp and a three-axis velocity.
// ============================================================================
interface tae_req_if
   import tae_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic        [TIME_BITS-1:0]  sim_time_ns;
   logic signed [VALUE_BITS-1:0] vel_x;
   logic signed [VALUE_BITS-1:0] vel_y;
   logic signed [VALUE_BITS-1:0] vel_z;

   modport source (output valid, sim_time_ns, vel_x, vel_y, vel_z, input ready);
   modport sink (input valid, sim_time_ns, vel_x, vel_y, vel_z, output ready);
endinterface

// ===== sv/tae_rsp_if.sv =====
// ============================================================================
// tae_rsp_if: result channel of the acceleration estimator
// One word is a timestamp and a filtered three-axis acceleration.
// ============================================================================
interface tae_rsp_if
   import tae_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic        [TIME_BITS-1:0]  stamp_ns;
   logic signed [VALUE_BITS-1:0] accel_x;
   logic signed [VALUE_BITS-1:0] accel_y;
   logic signed [VALUE_BITS-1:0] accel_z;

   modport source (output valid, stamp_ns, accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, stamp_ns, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== sv/throttled_accel_estimator.sv =====
// ============================================================================
// throttled_accel_estimator: low-pass filtered derivative of velocity
// Differentiates a three-axis velocity over time, smooths it with a
// first-order low-pass filter and publishes it at a throttled rate.
// ============================================================================
// Usage. Each word on req_chan is one simulation step (time in ns and a
// Q16.16 velocity). The block takes a word only when it is idle, then works
// on it with one shared adder/subtractor under a sequencer. In a step that
// advances time the restoring division of the scaled velocity step by dt,
// one quotient bit per cycle over VALUE_BITS + 30 bits per axis, dominates
// the work. The first step, or a step whose time does not advance, restarts
// the filter. A step yields zero or one word on rsp_chan, depending on the
// publish period. Results sit in an output register: the block goes back to
// idle and accepts the next step while a result still waits; it only holds
// in its final state if a new result is ready before the receiver took the
// old one. Reset is synchronous and returns the registers to their reset
// values and forgets the previous sample. csr_we writes the register at
// csr_index; writes belong in idle periods.
// ============================================================================
module throttled_accel_estimator
   import tae_pkg::*;
#(
   parameter int VALUE_BITS      = VALUE_BITS_DEF,
   parameter int TIME_BITS       = TIME_BITS_DEF,
   parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   tae_req_if.sink                   req_chan,
   tae_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int V  = VALUE_BITS;
   localparam int T  = TIME_BITS;
   localparam int F  = ALPHA_FRAC_BITS;
   // Width of |dv| * 1e9, also large enough for the filter product.
   localparam int PW = V + NS_BITS;
   // Multiplier shift register holds either 1e9 or alpha, left aligned.
   localparam int MW = (NS_BITS > F + 1) ? NS_BITS : F + 1;
   // The shared adder: every operand is nonnegative below 2^(XW-1) or a
   // small signed value, so the sign bit of the result is the borrow.
   localparam int XW = (T + 3 > PW + 1) ? T + 3 : PW + 1;
   localparam int CW = $clog2(PW);
   // dt at or above this bit gives alpha of one minus one LSB.
   localparam int HUGE_BIT = F + CSR_DATA_BITS;

   localparam logic [F:0]    ALPHA_ONE  = {1'b1, {F{1'b0}}};
   localparam logic [MW-1:0] NS_ALIGNED = MW'(NS_PER_SEC) << (MW - NS_BITS);
   localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (F - 1);
   localparam logic [V-1:0]  CAP_POS    = {1'b0, {(V-1){1'b1}}};
   localparam logic [V-1:0]  CAP_NEG    = {1'b1, {(V-1){1'b0}}};

   // Sequencer and control state.
   state_type state_ff, state_in;
   logic [CSR_DATA_BITS-1:0] tau_ff, tau_in;
   logic [CSR_DATA_BITS-1:0] period_ff, period_in;
   logic have_prev_ff, have_prev_in;
   logic have_emit_ff, have_emit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] axis_ff, axis_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic filt_ff, filt_in;

   // Filter state and the captured step.
   logic [T-1:0] prev_time_ff, prev_time_in;
   logic [T-1:0] last_emit_ff, last_emit_in;
   logic [T-1:0] now_ff, now_in;
   logic signed [V-1:0] vel_ff [3];
   logic signed [V-1:0] vel_in [3];
   logic signed [V-1:0] prev_vel_ff [3];
   logic signed [V-1:0] prev_vel_in [3];
   logic signed [V-1:0] est_ff [3];
   logic signed [V-1:0] est_in [3];

   // Working registers of the shared datapath.
   logic [T-1:0]      dt_ff, dt_in;
   logic [T:0]        den_ff, den_in;
   logic [T:0]        rem_ff, rem_in;
   logic [F:0]        alpha_ff, alpha_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [MW-1:0]     mplier_ff, mplier_in;
   logic [V-1:0]      mag_ff, mag_in;
   logic [V-1:0]      q_ff, q_in;
   logic              ovf_ff, ovf_in;
   logic              neg_ff, neg_in;
   logic signed [V:0] diff_ff, diff_in;
   logic signed [V-1:0] raw_ff, raw_in;

   // Output register.
   logic [T-1:0]        rsp_stamp_ff, rsp_stamp_in;
   logic signed [V-1:0] rsp_accel_ff [3];
   logic signed [V-1:0] rsp_accel_in [3];

   // Shared adder/subtractor.
   logic signed [XW-1:0] alu_a;
   logic signed [XW-1:0] alu_b;
   logic signed [XW-1:0] alu_res;
   logic                 alu_sub;
   logic                 alu_neg;
   logic                 alu_zero;

   logic [V-1:0] cap;
   logic [V-1:0] qsat;
   logic         est_in_range;
   logic [V-1:0] est_next;
   logic         throttle_hold;

   // Saturated quotient magnitude of the raw derivative.
   assign cap  = neg_ff ? CAP_NEG : CAP_POS;
   assign qsat = (ovf_ff || (q_ff > cap)) ? cap : q_ff;

   // Clamp of the updated estimate to the signed value range.
   assign est_in_range = (alu_res[XW-1:V-1] == '0) || (alu_res[XW-1:V-1] == '1);
   assign est_next = est_in_range ? alu_res[V-1:0] : (alu_res[XW-1] ? CAP_NEG : CAP_POS);

   // The step is suppressed while the publish period has not yet elapsed.
   assign throttle_hold = have_emit_ff && (period_ff != '0) && alu_neg;

   // Operand selection of the shared unit for each sequencer step.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_DT: begin
            alu_a   = XW'(now_ff);
            alu_b   = XW'(prev_time_ff);
            alu_sub = 1'b1;
         end
         ST_ALPHA_SEL: begin
            alu_a = XW'(tau_ff);
            alu_b = XW'(dt_ff);
         end
         ST_ALPHA_DIV: begin
            alu_a   = XW'({rem_ff, 1'b0});
            alu_b   = XW'(den_ff);
            alu_sub = 1'b1;
         end
         ST_DV: begin
            alu_a   = XW'(vel_ff[axis_ff]);
            alu_b   = XW'(prev_vel_ff[axis_ff]);
            alu_sub = 1'b1;
         end
         ST_ABS: begin
            alu_b   = XW'(diff_ff);
            alu_sub = 1'b1;
         end
         ST_MUL: begin
            alu_a = XW'({acc_ff, 1'b0});
            alu_b = mplier_ff[MW-1] ? XW'(mag_ff) : '0;
         end
         ST_DIV: begin
            alu_a   = XW'({rem_ff[T-1:0], acc_ff[PW-1]});
            alu_b   = XW'(dt_ff);
            alu_sub = 1'b1;
         end
         ST_RAW: begin
            alu_b   = XW'(qsat);
            alu_sub = neg_ff;
         end
         ST_DIFF: begin
            alu_a   = XW'(raw_ff);
            alu_b   = XW'(est_ff[axis_ff]);
            alu_sub = 1'b1;
         end
         ST_ROUND: begin
            alu_a = XW'(acc_ff);
            alu_b = XW'(ROUND_HALF);
         end
         ST_UPDATE: begin
            alu_a   = XW'(est_ff[axis_ff]);
            alu_b   = XW'(acc_ff[PW-1:F]);
            alu_sub = neg_ff;
         end
         ST_ELAPSED: begin
            alu_a   = XW'(now_ff);
            alu_b   = XW'(last_emit_ff);
            alu_sub = 1'b1;
         end
         ST_THROTTLE: begin
            alu_a   = XW'(rem_ff[T-1:0]);
            alu_b   = XW'(period_ff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_neg  = alu_res[XW-1];
   assign alu_zero = (alu_res == '0);

   // Sequencer: next state and datapath register updates.
   always_comb begin
      state_in     = state_ff;
      tau_in       = tau_ff;
      period_in    = period_ff;
      have_prev_in = have_prev_ff;
      have_emit_in = have_emit_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      filt_in      = filt_ff;
      prev_time_in = prev_time_ff;
      last_emit_in = last_emit_ff;
      now_in       = now_ff;
      vel_in       = vel_ff;
      prev_vel_in  = prev_vel_ff;
      est_in       = est_ff;
      dt_in        = dt_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      alpha_in     = alpha_ff;
      acc_in       = acc_ff;
      mplier_in    = mplier_ff;
      mag_in       = mag_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      diff_in      = diff_ff;
      raw_in       = raw_ff;
      rsp_stamp_in = rsp_stamp_ff;
      rsp_accel_in = rsp_accel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (csr_we) begin
         unique case (cfg_reg_type'(csr_index))
            CFG_FILTER_TAU:     tau_in    = csr_wdata;
            CFG_PUBLISH_PERIOD: period_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               now_in    = req_chan.sim_time_ns;
               vel_in[0] = req_chan.vel_x;
               vel_in[1] = req_chan.vel_y;
               vel_in[2] = req_chan.vel_z;
               axis_in   = '0;
               state_in  = ST_DT;
            end
         end
         ST_DT: begin
            // No previous sample or time not advancing restarts the filter.
            if (!have_prev_ff || alu_neg || alu_zero) begin
               est_in       = '{default: '0};
               have_emit_in = 1'b0;
               have_prev_in = 1'b1;
               state_in     = ST_ELAPSED;
            end else begin
               dt_in    = alu_res[T-1:0];
               state_in = ST_ALPHA_SEL;
            end
         end
         ST_ALPHA_SEL: begin
            filt_in = 1'b0;
            if (tau_ff == '0) begin
               alpha_in = ALPHA_ONE;
               state_in = ST_DV;
            end else if ((dt_ff >> HUGE_BIT) != '0) begin
               alpha_in = ALPHA_ONE - 1'b1;
               state_in = ST_DV;
            end else begin
               den_in   = alu_res[T:0];
               rem_in   = {1'b0, dt_ff};
               alpha_in = '0;
               cnt_in   = CW'(F - 1);
               state_in = ST_ALPHA_DIV;
            end
         end
         ST_ALPHA_DIV: begin
            // alpha = floor(dt * 2^F / (tau + dt)), one bit per cycle.
            rem_in   = alu_neg ? {rem_ff[T-1:0], 1'b0} : alu_res[T:0];
            alpha_in = {alpha_ff[F-1:0], !alu_neg};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DV;
            end
         end
         ST_DV: begin
            diff_in  = alu_res[V:0];
            filt_in  = 1'b0;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in = diff_ff[V];
            mag_in = diff_ff[V] ? alu_res[V-1:0] : diff_ff[V-1:0];
            acc_in = '0;
            if (filt_ff) begin
               mplier_in = MW'(alpha_ff) << (MW - F - 1);
               cnt_in    = CW'(F);
            end else begin
               mplier_in = NS_ALIGNED;
               cnt_in    = CW'(NS_BITS - 1);
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Shift-and-add product, multiplier bits from the top.
            acc_in    = alu_res[PW-1:0];
            mplier_in = {mplier_ff[MW-2:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (filt_ff) begin
                  state_in = ST_ROUND;
               end else begin
                  rem_in   = '0;
                  q_in     = '0;
                  ovf_in   = 1'b0;
                  cnt_in   = CW'(PW - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // Restoring division of the product by dt. Quotient bits that
            // leave the top only mark saturation.
            acc_in = {acc_ff[PW-2:0], 1'b0};
            rem_in = alu_neg ? {rem_ff[T-1:0], acc_ff[PW-1]} : alu_res[T:0];
            q_in   = {q_ff[V-2:0], !alu_neg};
            ovf_in = ovf_ff || q_ff[V-1];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            raw_in   = alu_res[V-1:0];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = alu_res[V:0];
            filt_in  = 1'b1;
            state_in = ST_ABS;
         end
         ST_ROUND: begin
            acc_in   = alu_res[PW-1:0];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            est_in[axis_ff] = est_next;
            if (axis_ff == 2'd2) begin
               state_in = ST_ELAPSED;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DV;
            end
         end
         ST_ELAPSED: begin
            rem_in       = {1'b0, alu_res[T-1:0]};
            prev_time_in = now_ff;
            prev_vel_in  = vel_ff;
            have_prev_in = 1'b1;
            state_in     = ST_THROTTLE;
         end
         ST_THROTTLE: begin
            if (throttle_hold) begin
               state_in = ST_IDLE;
            end else begin
               last_emit_in = now_ff;
               have_emit_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_stamp_in = now_ff;
               rsp_accel_in = est_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tau_ff       <= FILTER_TAU_RESET;
         period_ff    <= PUBLISH_PERIOD_RESET;
         have_prev_ff <= 1'b0;
         have_emit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tau_ff       <= tau_in;
         period_ff    <= period_in;
         have_prev_ff <= have_prev_in;
         have_emit_ff <= have_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      cnt_ff       <= cnt_in;
      filt_ff      <= filt_in;
      prev_time_ff <= prev_time_in;
      last_emit_ff <= last_emit_in;
      now_ff       <= now_in;
      vel_ff       <= vel_in;
      prev_vel_ff  <= prev_vel_in;
      est_ff       <= est_in;
      dt_ff        <= dt_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      alpha_ff     <= alpha_in;
      acc_ff       <= acc_in;
      mplier_ff    <= mplier_in;
      mag_ff       <= mag_in;
      q_ff         <= q_in;
      ovf_ff       <= ovf_in;
      neg_ff       <= neg_in;
      diff_ff      <= diff_in;
      raw_ff       <= raw_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_accel_ff <= rsp_accel_in;
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.stamp_ns = rsp_stamp_ff;
   assign rsp_chan.accel_x = rsp_accel_ff[0];
   assign rsp_chan.accel_y = rsp_accel_ff[1];
   assign rsp_chan.accel_z = rsp_accel_ff[2];

   // Once a sample has been seen, only reset forgets it.
   a_prev_kept: assert property (@(posedge clock) disable iff (reset)
      !$fell(have_prev_ff))
      else $error("previous sample flag dropped outside reset");

   // The division remainders stay below their divisors.
   a_alpha_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALPHA_DIV |-> rem_ff < den_ff)
      else $error("alpha division remainder out of range");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < {1'b0, dt_ff})
      else $error("derivative division remainder out of range");

   // The filter gain never exceeds one.
   a_alpha_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL && filt_ff |-> alpha_ff <= ALPHA_ONE)
      else $error("filter gain above one");

   // A freshly published word carries the time of the last emission.
   a_stamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> have_emit_ff && rsp_stamp_ff == last_emit_ff)
      else $error("published stamp does not match emission time");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the throttled acceleration estimator
// Drives simulation steps into the estimator and predicts every published
// acceleration word in a scoreboard of its own. Runs directed corner steps,
// then randomized step sequences under several filter and publish settings,
// with random idling on both channels and one long receiver hold-off.
// ============================================================================
module tb_top;
   import tae_pkg::*;

   localparam int TIME_W  = TIME_BITS_DEF;
   localparam int VALUE_W = VALUE_BITS_DEF;
   localparam int ALPHA_F = ALPHA_FRAC_BITS_DEF;

   localparam longint VALUE_MAX = (64'sd1 <<< (VALUE_W - 1)) - 1;
   localparam logic signed [VALUE_W-1:0] VEL_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VEL_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 11;
   // A step that advances time finishes well within this drain pause, so after
   // the last expected word the estimator is surely back in idle.
   localparam int DRAIN_CYCLES = 500;
   // The receiver refuses results this long once, so that the output
   // register and the sequencer both fill and the input backs up.
   localparam int HOLD_OFF_CYCLES = 3000;
   // Longest legal quiet stretch: the hold-off, plus a step's work, plus a
   // long sender gap, plus a drain pause. The limit is several times that.
   localparam int WATCHDOG_LIMIT = 20000;

   // One accepted input word: a step of the simulation.
   typedef struct {
      logic        [TIME_W-1:0]  sim_time_ns;
      logic signed [VALUE_W-1:0] vel [3];
   } step_word_type;

   // One published result word.
   typedef struct {
      logic        [TIME_W-1:0]  stamp_ns;
      logic signed [VALUE_W-1:0] accel [3];
   } accel_word_type;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the filter state and the registers,
   // predicts the published words of each accepted step and checks the
   // words that come out against them, oldest first.
   // -------------------------------------------------------------------------
   class accel_scoreboard;
      logic [CSR_DATA_BITS-1:0] tau_ns;
      logic [CSR_DATA_BITS-1:0] period_ns;
      bit                       have_prev;
      bit                       have_emitted;
      logic [TIME_W-1:0]        prev_time_ns;
      logic [TIME_W-1:0]        last_emit_ns;
      longint                   prev_vel [3];
      longint                   estimate [3];
      accel_word_type           pending_accel [$];
      int mismatches;
      int steps;
      int results;
      int restarts;
      int throttled;

      function new();
         int i;
         tau_ns       = FILTER_TAU_RESET;
         period_ns    = PUBLISH_PERIOD_RESET;
         have_prev    = 1'b0;
         have_emitted = 1'b0;
         prev_time_ns = '0;
         last_emit_ns = '0;
         for (i = 0; i < 3; i++) begin
            prev_vel[i] = 0;
            estimate[i] = 0;
         end
         mismatches = 0;
         steps      = 0;
         results    = 0;
         restarts   = 0;
         throttled  = 0;
      endfunction

      function void write_reg(cfg_reg_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CFG_FILTER_TAU:     tau_ns = value;
            CFG_PUBLISH_PERIOD: period_ns = value;
            default: ;
         endcase
      endfunction

      function longint clamp_value(longint v);
         if (v > VALUE_MAX) return VALUE_MAX;
         if (v < -VALUE_MAX - 1) return -VALUE_MAX - 1;
         return v;
      endfunction

      // Filter gain dt/(tau+dt) as a Q0.F fraction, one LSB below one for a huge
      // dt, or exactly one when the time constant is zero.
      function longint unsigned alpha_of(longint unsigned dt);
         longint unsigned one;
         one = 64'd1 << ALPHA_F;
         if (tau_ns == 0) return one;
         if (dt >= (64'd1 << (ALPHA_F + 32))) return one - 1;
         return (dt << ALPHA_F) / (dt + tau_ns);
      endfunction

      // Velocity step over dt, scaled to per second, truncated toward zero
      // and saturated to the value range.
      function longint raw_accel(longint dv, longint unsigned dt);
         bit              neg;
         longint unsigned mag;
         longint unsigned q;
         longint unsigned cap;
         neg = dv < 0;
         mag = neg ? -dv : dv;
         cap = VALUE_MAX + (neg ? 1 : 0);
         q = (mag * NS_PER_SEC) / dt;
         if (q > cap) q = cap;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      // One low-pass update: the step is rounded half away from zero.
      function longint filter_axis(longint acc, longint raw, longint unsigned alpha);
         longint          diff;
         bit              neg;
         longint unsigned mag;
         longint unsigned delta;
         diff  = raw - acc;
         neg   = diff < 0;
         mag   = neg ? -diff : diff;
         delta = (mag * alpha + (64'd1 << (ALPHA_F - 1))) >> ALPHA_F;
         return clamp_value(neg ? acc - longint'(delta) : acc + longint'(delta));
      endfunction

      function void note_step(step_word_type s);
         longint unsigned   dt;
         longint unsigned   alpha;
         logic [TIME_W-1:0] since_emit;
         accel_word_type    w;
         int                i;
         steps++;
         if (!have_prev || s.sim_time_ns <= prev_time_ns) begin
            // First step, or time stood still or ran back: restart the filter.
            restarts++;
            for (i = 0; i < 3; i++) estimate[i] = 0;
            have_emitted = 1'b0;
            have_prev    = 1'b1;
         end else begin
            dt    = s.sim_time_ns - prev_time_ns;
            alpha = alpha_of(dt);
            for (i = 0; i < 3; i++) begin
               estimate[i] = filter_axis(estimate[i],
                                         raw_accel(longint'(s.vel[i]) - prev_vel[i], dt),
                                         alpha);
            end
         end
         for (i = 0; i < 3; i++) prev_vel[i] = s.vel[i];
         prev_time_ns = s.sim_time_ns;

         since_emit = s.sim_time_ns - last_emit_ns;
         if (have_emitted && period_ns != 0 && since_emit < period_ns) begin
            throttled++;
            return;
         end
         last_emit_ns = s.sim_time_ns;
         have_emitted = 1'b1;
         w.stamp_ns = s.sim_time_ns;
         for (i = 0; i < 3; i++) w.accel[i] = estimate[i][VALUE_W-1:0];
         pending_accel.push_back(w);
      endfunction

      function void check_word(accel_word_type got);
         accel_word_type want;
         int             i;
         if (pending_accel.size() == 0) begin
            mismatches++;
            $display("%0t ns: result word with no step waiting, stamp_ns %0d",
                     $time, got.stamp_ns);
            return;
         end
         want = pending_accel.pop_front();
         results++;
         if (got.stamp_ns !== want.stamp_ns) begin
            mismatches++;
            $display("%0t ns: stamp_ns expected %0d, got %0d",
                     $time, want.stamp_ns, got.stamp_ns);
         end
         for (i = 0; i < 3; i++) begin
            // 8'd120 is the letter x; the axes follow in order.
            if (got.accel[i] !== want.accel[i]) begin
               mismatches++;
               $display("%0t ns: accel_%c of stamp %0d expected %0d, got %0d",
                        $time, 8'd120 + i, want.stamp_ns, want.accel[i], got.accel[i]);
            end
         end
      endfunction

      function void report_leftovers();
         if (pending_accel.size() != 0) begin
            mismatches += pending_accel.size();
            $display("%0t ns: %0d expected result words never arrived, first stamp %0d",
                     $time, pending_accel.size(), pending_accel[0].stamp_ns);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block itself.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   tae_req_if req_if ();
   tae_rsp_if rsp_if ();

   throttled_accel_estimator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   accel_scoreboard sb;

   // When set, neither side idles at random.
   bit steady = 1'b0;
   // Set by the stimulus once; the receiver clears it as it starts its
   // long hold-off.
   bit hold_off_due = 1'b0;
   int settings = 0;

   // Running time and velocity of the random step sequences.
   logic        [TIME_W-1:0]  clk_ns;
   logic signed [VALUE_W-1:0] vcur [3];

   step_word_type  seen_req;
   accel_word_type seen_rsp;

   // -------------------------------------------------------------------------
   // Monitors. Both sample at the rising edge, where the handshake counts.
   // A result word always belongs to a step accepted at an earlier edge, so the
   // order of the two monitors within an edge does not matter.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         seen_req.sim_time_ns = req_if.sim_time_ns;
         seen_req.vel[0]      = req_if.vel_x;
         seen_req.vel[1]      = req_if.vel_y;
         seen_req.vel[2]      = req_if.vel_z;
         sb.note_step(seen_req);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_rsp.stamp_ns = rsp_if.stamp_ns;
         seen_rsp.accel[0] = rsp_if.accel_x;
         seen_rsp.accel[1] = rsp_if.accel_y;
         seen_rsp.accel[2] = rsp_if.accel_z;
         sb.check_word(seen_rsp);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. Takes result words with ready low in about a quarter of the
   // cycles, never idles while steady is set, and once holds off for a long
   // stretch that it counts itself.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= 26);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog. Any cycle in which a word moves on either channel restarts
   // the count; a hang ends the run as a failure.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t ns: no word moved for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver tasks. All of them start and end just after a rising edge and
   // drive with nonblocking assignments, so valid is never lowered and
   // raised within one time step.
   // -------------------------------------------------------------------------

   // Offers one step and returns at the edge where it is accepted. Valid
   // stays high afterwards, so back-to-back steps need no gap between them.
   task automatic send_step(input logic [TIME_W-1:0] t,
                            input logic signed [VALUE_W-1:0] vx,
                            input logic signed [VALUE_W-1:0] vy,
                            input logic signed [VALUE_W-1:0] vz);
      // Now and then a long gap, so that the next step lands at any point
      // of the estimator's work on the previous one.
      if (!steady && $urandom_range(15) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 450)) @(posedge clock);
      end
      while (!steady && $urandom_range(99) < 26) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.sim_time_ns <= t;
      req_if.vel_x       <= vx;
      req_if.vel_y       <= vy;
      req_if.vel_z       <= vz;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // Brings the estimator to idle: every expected word has come out, and
   // a step that publishes nothing has had time to finish as well.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_accel.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the filter time constant, then the publish period, on consecutive edges; idle periods only.
   task automatic write_regs(input logic [CSR_DATA_BITS-1:0] tau,
                             input logic [CSR_DATA_BITS-1:0] period);
      csr_we    <= 1'b1;
      csr_index <= CFG_FILTER_TAU;
      csr_wdata <= tau;
      @(posedge clock);
      sb.write_reg(CFG_FILTER_TAU, tau);
      csr_index <= CFG_PUBLISH_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      sb.write_reg(CFG_PUBLISH_PERIOD, period);
      csr_we <= 1'b0;
      settings++;
   endtask

   // A run of random steps under one register setting. Most steps advance
   // time by about a physics tick and nudge the velocity; the rest repeat
   // or rewind time, jump anywhere, advance by a few ns or by a huge span,
   // or set an axis to an extreme or to random bits.
   task automatic random_phase(input int count,
                               input logic [CSR_DATA_BITS-1:0] tau,
                               input logic [CSR_DATA_BITS-1:0] period,
                               input bit calm,
                               input bit squeeze);
      int n;
      int i;
      int pick;
      int a;
      settle();
      write_regs(tau, period);
      steady = calm;
      if (squeeze) hold_off_due = 1'b1;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 6) clk_ns = clk_ns - $urandom_range(0, 5000);
         else if (pick < 10) clk_ns = TIME_W'({$urandom(), $urandom()});
         else if (pick < 14) clk_ns = clk_ns + $urandom_range(1, 20);
         else if (pick < 17) begin
            clk_ns = clk_ns + TIME_W'({$urandom_range(0, 4095), $urandom()});
         end
         else clk_ns = clk_ns + $urandom_range(200_000, 2_500_000);
         for (i = 0; i < 3; i++) begin
            a = $urandom_range(99);
            if (a < 5) vcur[i] = $urandom();
            else if (a < 8) vcur[i] = a[0] ? VEL_MAX : VEL_MIN;
            else vcur[i] = vcur[i] + int'($urandom_range(0, 800_000)) - 400_000;
         end
         send_step(clk_ns, vcur[0], vcur[1], vcur[2]);
      end
      steady = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      req_if.valid       = 1'b0;
      req_if.sim_time_ns = '0;
      req_if.vel_x       = '0;
      req_if.vel_y       = '0;
      req_if.vel_z       = '0;
      csr_we             = 1'b0;
      csr_index          = CFG_FILTER_TAU;
      csr_wdata          = '0;
      clk_ns             = '0;
      vcur[0]            = '0;
      vcur[1]            = '0;
      vcur[2]            = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed steps under the reset settings (tau 20 ms, period 2 ms).
      // The first step always publishes a zero estimate.
      send_step(48'd1000, 0, 0, 0);
      // One millisecond later: filtered, but held back by the period.
      send_step(48'd1_001_000, 32'sd65536, -32'sd65536, 0);
      // Full-scale velocity swing: the derivative saturates both ways.
      send_step(48'd3_001_000, VEL_MAX, VEL_MIN, 0);
      // One nanosecond step with the opposite swing.
      send_step(48'd3_001_001, VEL_MIN, VEL_MAX, 32'sd12345);
      // Time stands still, then runs back: both restart the filter.
      send_step(48'd3_001_001, 1, 2, 3);
      send_step(48'd500, -1, -2, -3);
      // A huge time step, then the top of the time range.
      send_step(48'h8000_0000_01F4, VEL_MAX, 0, VEL_MIN);
      send_step(48'hFFFF_FFFF_FFFF, VEL_MAX, VEL_MAX, VEL_MIN);
      // Time wraps to zero: another restart.
      send_step(48'd0, 0, VEL_MIN, VEL_MAX);

      // No smoothing and no throttling: every step publishes the raw value.
      settle();
      write_regs(32'd0, 32'd0);
      send_step(48'd10, 100, -100, 0);
      send_step(48'd20, VEL_MAX, VEL_MIN, -1);
      send_step(48'd1_000_020, 0, 0, 0);
      send_step(48'd1_000_021, -1, 1, VEL_MAX);

      // Slowest filter and longest period.
      settle();
      write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_step(48'd2_000_000, 32'sd655360, 0, -32'sd655360);
      send_step(48'd2_000_000, 32'sd655360, 0, -32'sd655360);
      send_step(48'd3_000_000, VEL_MAX, VEL_MIN, 0);
      send_step(48'h0001_0010_0000, 0, 0, 0);
      send_step(48'h0001_0010_0001, VEL_MIN, 7, VEL_MAX);

      // Random part. The receiver's long hold-off falls in a phase that
      // publishes every step, so results back up into the input.
      random_phase(150, FILTER_TAU_RESET, PUBLISH_PERIOD_RESET, 1'b0, 1'b0);
      random_phase(150, 32'd0, 32'd0, 1'b0, 1'b1);
      random_phase(130, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
      random_phase(150, $urandom_range(1, 50_000_000), $urandom_range(0, 5_000_000),
                   1'b1, 1'b0);
      random_phase(100, $urandom(), 32'hFFFF_FFFF, 1'b0, 1'b0);
      random_phase(150, 32'd0, $urandom_range(0, 3_000_000), 1'b0, 1'b0);
      random_phase(130, $urandom_range(1, 1000), 32'd1, 1'b0, 1'b0);
      random_phase(130, $urandom(), $urandom(), 1'b0, 1'b0);
      random_phase(130, 32'd1, $urandom_range(0, 2_000_000), 1'b0, 1'b0);
      random_phase(130, FILTER_TAU_RESET, PUBLISH_PERIOD_RESET, 1'b0, 1'b0);

      settle();
      sb.report_leftovers();
      $display("Run covered %0d steps under %0d register settings, %0d result words compared,",
               sb.steps, settings + 1, sb.results);
      $display("with %0d filter restarts and %0d steps held back by the publish period.",
               sb.restarts, sb.throttled);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
